// File: src/ascii_line_to_fixed_point_top_defines.svh
// ----------------------------------------------------------------------------
// ASCII line to fixed point: assertion macros
// Shared assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef ASCII_LINE_TO_FIXED_POINT_TOP_DEFINES_SVH
`define ASCII_LINE_TO_FIXED_POINT_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/alp_pkg.sv
// ----------------------------------------------------------------------------
// ASCII line to fixed point: shared package
// Character codes, widths, limits, state encodings and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package alp_pkg;

  localparam int MANT_W      = 64;
  localparam int SCALE_W     = 10;
  localparam int EXP_W       = 10;
  localparam int EXP_PROD_W  = 14;
  localparam int E_W         = 12;
  localparam int CNT_W       = 11;
  localparam int CHUNK_W     = 16;
  localparam int CHUNKS      = 5;
  localparam int WORK_W      = CHUNK_W * CHUNKS;
  localparam int CHUNK_IDX_W = 3;
  localparam int REM_W       = 4;
  localparam int CUR_W       = REM_W + CHUNK_W;
  localparam int PROD_W      = 2 * CUR_W;
  localparam int RECIP_SHIFT = 23;
  localparam int OUT_W       = 32;

  localparam logic [7:0] TERM_RESET = 8'd10;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_E_LO    = 8'h65;
  localparam logic [7:0] CH_E_UP    = 8'h45;

  localparam logic signed [SCALE_W-1:0] SCALE_MAX = 10'sd511;
  localparam logic signed [SCALE_W-1:0] SCALE_MIN = -10'sd511;
  localparam logic [EXP_W-1:0]          EXP_CAP   = 10'd999;

  localparam logic [MANT_W-1:0] Q_INT_LIMIT = 64'd32768;
  localparam logic [MANT_W-1:0] POS_LIMIT   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [MANT_W-1:0] NEG_LIMIT   = 64'h0000_0000_8000_0000;

  // Reciprocal of ten, exact for quotients of 20-bit dividends.
  localparam logic [CUR_W-1:0] RECIP_TEN = 20'hCCCCD;

  typedef enum logic [7:0] {
    PH_START      = 8'b0000_0001,
    PH_ZEROS      = 8'b0000_0010,
    PH_INT        = 8'b0000_0100,
    PH_DOT        = 8'b0000_1000,
    PH_FRAC       = 8'b0001_0000,
    PH_EXP_SIGN   = 8'b0010_0000,
    PH_EXP_DIGITS = 8'b0100_0000,
    PH_DONE       = 8'b1000_0000
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RUN    = 3'b010,
    S_FINISH = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic take_byte;
    logic conv_start;
    logic conv_step;
    logic load_out;
    logic clear_line;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_term;
    logic conv_done;
    logic out_free;
  } ctrl_status_t;

  typedef struct packed {
    logic                      is_negative;
    logic [MANT_W-1:0]         mantissa;
    logic signed [SCALE_W-1:0] scale;
    logic [EXP_W-1:0]          exp_mag;
    logic                      exp_neg;
  } parse_state_t;

endpackage

// File: src/alp_ctrl.sv
// ----------------------------------------------------------------------------
// ASCII line to fixed point: controller
// Takes bytes while idle, runs the conversion on a terminator and hands the
// result to the output register once it is free.
// ----------------------------------------------------------------------------
module alp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  alp_pkg::ctrl_status_t status,
  output alp_pkg::ctrl_cmd_t    cmd
);
  import alp_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.take_byte  = accept && !status.is_term;
    cmd.conv_start = accept && status.is_term;
    unique case (state)
      S_IDLE: begin
        if (cmd.conv_start) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (status.conv_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.conv_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.clear_line = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/alp_parser.sv
// ----------------------------------------------------------------------------
// ASCII line to fixed point: byte parser
// Holds the terminator register and the per-line parse state, and folds one
// byte into it per command.
// ----------------------------------------------------------------------------
module alp_parser #(
  parameter int LINE_MAX        = 64,
  parameter int MAX_MANT_DIGITS = 19
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  input  logic [7:0]            rx_byte,
  input  alp_pkg::ctrl_cmd_t    cmd,
  output logic                  is_term,
  output alp_pkg::parse_state_t pstate
);
  import alp_pkg::*;

  localparam int LEN_W = $clog2(LINE_MAX);
  localparam int DIG_W = $clog2(MAX_MANT_DIGITS + 1);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_MAX - 1);
  localparam logic [DIG_W-1:0] DIG_MAX  = DIG_W'(MAX_MANT_DIGITS);

  logic [7:0]                line_terminator;
  phase_t                    phase;
  logic                      is_negative;
  logic [MANT_W-1:0]         mantissa;
  logic [DIG_W-1:0]          mant_digits;
  logic signed [SCALE_W-1:0] scale;
  logic [EXP_W-1:0]          exp_mag;
  logic                      exp_neg;
  logic [LEN_W-1:0]          line_length;

  phase_t                    phase_next;
  logic                      is_negative_next;
  logic [MANT_W-1:0]         mantissa_next;
  logic [DIG_W-1:0]          mant_digits_next;
  logic signed [SCALE_W-1:0] scale_next;
  logic [EXP_W-1:0]          exp_mag_next;
  logic                      exp_neg_next;

  logic                  is_digit;
  logic                  is_exp_mark;
  logic [3:0]            digit;
  logic                  do_int;
  logic                  do_frac;
  logic                  do_exp;
  logic [MANT_W-1:0]     mant_x10;
  logic [EXP_PROD_W-1:0] exp_x10;
  logic                  clear_now;

  assign is_term     = (rx_byte == line_terminator);
  assign is_digit    = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_exp_mark = (rx_byte == CH_E_LO) || (rx_byte == CH_E_UP);
  assign digit       = rx_byte[3:0];
  assign mant_x10    = (mantissa << 3) + (mantissa << 1) + MANT_W'(digit);
  assign exp_x10     = (EXP_PROD_W'(exp_mag) << 3) + (EXP_PROD_W'(exp_mag) << 1)
                       + EXP_PROD_W'(digit);
  assign clear_now   = cmd.clear_line || (cmd.take_byte && (line_length >= LEN_LAST));

  always_comb begin
    phase_next       = phase;
    is_negative_next = is_negative;
    exp_neg_next     = exp_neg;
    do_int           = 1'b0;
    do_frac          = 1'b0;
    do_exp           = 1'b0;
    unique case (phase)
      PH_START, PH_ZEROS: begin
        priority if (rx_byte == CH_MINUS && phase == PH_START) begin
          is_negative_next = 1'b1;
          phase_next       = PH_ZEROS;
        end else if (rx_byte == CH_ZERO) begin
          phase_next = PH_ZEROS;
        end else if (is_digit) begin
          do_int     = 1'b1;
          phase_next = PH_INT;
        end else if (rx_byte == CH_DOT) begin
          phase_next = PH_DOT;
        end else if (is_exp_mark) begin
          phase_next = PH_EXP_SIGN;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_INT: begin
        priority if (is_digit) begin
          do_int = 1'b1;
        end else if (rx_byte == CH_DOT) begin
          phase_next = PH_DOT;
        end else if (is_exp_mark) begin
          phase_next = PH_EXP_SIGN;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DOT, PH_FRAC: begin
        priority if (is_digit) begin
          do_frac    = 1'b1;
          phase_next = PH_FRAC;
        end else if (phase == PH_FRAC && is_exp_mark) begin
          phase_next = PH_EXP_SIGN;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_EXP_SIGN: begin
        priority if (rx_byte == CH_PLUS) begin
          phase_next = PH_EXP_DIGITS;
        end else if (rx_byte == CH_MINUS) begin
          exp_neg_next = 1'b1;
          phase_next   = PH_EXP_DIGITS;
        end else if (is_digit) begin
          do_exp     = 1'b1;
          phase_next = PH_EXP_DIGITS;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_EXP_DIGITS: begin
        if (is_digit) begin
          do_exp = 1'b1;
        end else begin
          phase_next = PH_DONE;
        end
      end
      default: phase_next = PH_DONE;
    endcase
  end

  always_comb begin
    mantissa_next    = mantissa;
    mant_digits_next = mant_digits;
    scale_next       = scale;
    exp_mag_next     = exp_mag;
    if (do_int) begin
      if (mant_digits < DIG_MAX) begin
        mantissa_next    = mant_x10;
        mant_digits_next = mant_digits + DIG_W'(1);
      end else if (scale < SCALE_MAX) begin
        scale_next = scale + SCALE_W'(1);
      end
    end
    if (do_frac) begin
      if (mantissa == '0 && digit == 4'd0) begin
        if (scale > SCALE_MIN) begin
          scale_next = scale - SCALE_W'(1);
        end
      end else if (mant_digits < DIG_MAX) begin
        mantissa_next    = mant_x10;
        mant_digits_next = mant_digits + DIG_W'(1);
        if (scale > SCALE_MIN) begin
          scale_next = scale - SCALE_W'(1);
        end
      end
    end
    if (do_exp) begin
      if (exp_x10 > EXP_PROD_W'(EXP_CAP)) begin
        exp_mag_next = EXP_CAP;
      end else begin
        exp_mag_next = exp_x10[EXP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_terminator <= TERM_RESET;
    end else if (cfg_wr_en) begin
      line_terminator <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_now) begin
      phase       <= PH_START;
      is_negative <= 1'b0;
      mantissa    <= '0;
      mant_digits <= '0;
      scale       <= '0;
      exp_mag     <= '0;
      exp_neg     <= 1'b0;
      line_length <= '0;
    end else if (cmd.take_byte) begin
      phase       <= phase_next;
      is_negative <= is_negative_next;
      mantissa    <= mantissa_next;
      mant_digits <= mant_digits_next;
      scale       <= scale_next;
      exp_mag     <= exp_mag_next;
      exp_neg     <= exp_neg_next;
      line_length <= line_length + LEN_W'(1);
    end
  end

  assign pstate.is_negative = is_negative;
  assign pstate.mantissa    = mantissa;
  assign pstate.scale       = scale;
  assign pstate.exp_mag     = exp_mag;
  assign pstate.exp_neg     = exp_neg;

endmodule

// File: src/alp_conv.sv
// ----------------------------------------------------------------------------
// ASCII line to fixed point: converter and output register
// Scales the mantissa by the power of ten, one multiply by ten per cycle or
// one 16-bit chunk of a divide by ten per cycle, then clamps to Q16.16.
// ----------------------------------------------------------------------------
module alp_conv (
  input  logic                  clk,
  input  logic                  rst,
  input  alp_pkg::ctrl_cmd_t    cmd,
  input  alp_pkg::parse_state_t pstate,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic signed [31:0]    value,
  output logic                  saturated,
  output logic                  conv_done,
  output logic                  out_free
);
  import alp_pkg::*;

  logic                   div_mode;
  logic                   neg;
  logic                   over;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       target;
  logic [CHUNK_IDX_W-1:0] chunk;
  logic [REM_W-1:0]       rem;
  logic [WORK_W-1:0]      work;

  logic signed [E_W-1:0] scale_x;
  logic signed [E_W-1:0] exp_x;
  logic signed [E_W-1:0] e_full;
  logic signed [E_W-1:0] e_neg;
  logic [CNT_W-1:0]      e_abs;

  logic [MANT_W-1:0] v;
  logic [MANT_W-1:0] v_x10;
  logic              mul_done;
  logic              div_done;
  logic [CUR_W-1:0]  cur;
  logic [PROD_W-1:0] prod;
  logic [CHUNK_W-1:0] quot;
  logic [CUR_W-1:0]  rem_full;

  logic              over_f;
  logic              sat_f;
  logic [MANT_W-1:0] mag;
  logic [MANT_W-1:0] limit;
  logic [MANT_W-1:0] mag_f;
  logic [OUT_W-1:0]  val_f;

  assign scale_x = {{(E_W - SCALE_W){pstate.scale[SCALE_W-1]}}, pstate.scale};
  assign exp_x   = {{(E_W - EXP_W){1'b0}}, pstate.exp_mag};
  assign e_full  = pstate.exp_neg ? (scale_x - exp_x) : (scale_x + exp_x);
  assign e_neg   = -e_full;
  assign e_abs   = e_full[E_W-1] ? e_neg[CNT_W-1:0] : e_full[CNT_W-1:0];

  assign v        = work[MANT_W-1:0];
  assign v_x10    = (v << 3) + (v << 1);
  assign mul_done = (cnt == target) || over || (v == '0);
  assign div_done = (chunk == '0) && ((cnt == target) || (work == '0));
  assign conv_done = div_mode ? div_done : mul_done;

  assign cur      = {rem, work[WORK_W-1 -: CHUNK_W]};
  assign prod     = PROD_W'(cur) * PROD_W'(RECIP_TEN);
  assign quot     = prod[RECIP_SHIFT +: CHUNK_W];
  assign rem_full = cur - ((CUR_W'(quot) << 3) + (CUR_W'(quot) << 1));

  assign over_f = div_mode ? (work[WORK_W-1 -: CHUNK_W] != '0)
                           : (over || (v > Q_INT_LIMIT));
  assign mag    = div_mode ? work[MANT_W-1:0] : {v[MANT_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
  assign limit  = neg ? NEG_LIMIT : POS_LIMIT;
  assign sat_f  = over_f || (mag > limit);
  assign mag_f  = sat_f ? limit : mag;
  assign val_f  = neg ? (OUT_W'(0) - mag_f[OUT_W-1:0]) : mag_f[OUT_W-1:0];

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_mode <= 1'b0;
      over     <= 1'b0;
      cnt      <= '0;
      chunk    <= '0;
      rem      <= '0;
    end else if (cmd.conv_start) begin
      div_mode <= e_full[E_W-1];
      over     <= 1'b0;
      cnt      <= '0;
      chunk    <= '0;
      rem      <= '0;
    end else if (cmd.conv_step) begin
      if (div_mode) begin
        if (chunk == CHUNK_IDX_W'(CHUNKS - 1)) begin
          chunk <= '0;
          rem   <= '0;
          cnt   <= cnt + CNT_W'(1);
        end else begin
          chunk <= chunk + CHUNK_IDX_W'(1);
          rem   <= rem_full[REM_W-1:0];
        end
      end else if (v > Q_INT_LIMIT) begin
        over <= 1'b1;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_start) begin
      neg    <= pstate.is_negative;
      target <= e_abs;
      if (e_full[E_W-1]) begin
        work <= {pstate.mantissa, {CHUNK_W{1'b0}}};
      end else begin
        work <= {{CHUNK_W{1'b0}}, pstate.mantissa};
      end
    end else if (cmd.conv_step) begin
      if (div_mode) begin
        work <= {work[WORK_W-CHUNK_W-1:0], quot};
      end else if (v <= Q_INT_LIMIT) begin
        work <= {{CHUNK_W{1'b0}}, v_x10};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      value     <= val_f;
      saturated <= sat_f;
    end
  end

endmodule

// File: src/ascii_line_to_fixed_point_top.sv
// ----------------------------------------------------------------------------
// ASCII line to fixed point: top level
// Parses terminated lines of decimal text into signed Q16.16 values with
// a saturation flag.
//
//   Channel   Handshake             Beat payload
//   -------   -------------------   -----------------------------
//   input     in_valid / in_stall   rx_byte
//   output    out_valid / out_stall value, saturated
//   config    cfg_wr_en             cfg_wr_data (line terminator)
//
// A non-terminator byte is taken in the cycle it is offered. A terminator
// starts the conversion: repeated multiplies by ten for a non-negative power,
// or repeated divides by ten, one 16-bit chunk at a time, for a negative one,
// at most about 25 divides before the value reaches zero.
// in_stall is high from a terminator beat until its result is in the output
// register, which holds while out_stall is high. rst is synchronous.
// ----------------------------------------------------------------------------
`include "ascii_line_to_fixed_point_top_defines.svh"

module ascii_line_to_fixed_point_top #(
  parameter int LINE_MAX        = 64,
  parameter int MAX_MANT_DIGITS = 19
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic               saturated
);
  import alp_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  parse_state_t pstate;
  logic         is_term;
  logic         conv_done;
  logic         out_free;

  assign status.is_term   = is_term;
  assign status.conv_done = conv_done;
  assign status.out_free  = out_free;

  alp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  alp_parser #(
    .LINE_MAX        (LINE_MAX),
    .MAX_MANT_DIGITS (MAX_MANT_DIGITS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx_byte     (rx_byte),
    .cmd         (cmd),
    .is_term     (is_term),
    .pstate      (pstate)
  );

  alp_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pstate    (pstate),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .value     (value),
    .saturated (saturated),
    .conv_done (conv_done),
    .out_free  (out_free)
  );

  `ALP_ASSERT_NEXT(a_term_blocks_input, in_valid && !in_stall && status.is_term, in_stall, "input taken during conversion")
  `ALP_ASSERT_NOW(a_sat_is_clamped, out_valid && saturated, value == 32'sh7FFF_FFFF || value == 32'sh8000_0000, "saturated result not clamped")
  `ALP_ASSERT_NOW(a_load_when_free, cmd.load_out, !out_valid || !out_stall, "result loaded over a waiting beat")

endmodule
